@@ src/pid_position_controller_top_assert.svh @@
// Assertion macros used by the checker file of the position controller.
`ifndef PID_POSITION_CONTROLLER_TOP_ASSERT_SVH
`define PID_POSITION_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("position controller check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define PPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("position controller check failed");

`endif

@@ src/ppc_pkg.sv @@
// Package with the types, constants and codes of the position controller.
package ppc_pkg;

    localparam int POS_W     = 11;
    localparam int MS_W      = 16;
    localparam int GAIN_W    = 20;
    localparam int FRAC_BITS = 16;
    localparam int USED_W    = 13;
    localparam int ERR_W     = 13;
    localparam int DIFF_W    = ERR_W + 1;
    localparam int PRODA_W   = ERR_W + MS_W;
    localparam int PTERM_W   = ERR_W + GAIN_W;
    localparam int NUMI_W    = PRODA_W + GAIN_W;
    localparam int DIFFK_W   = DIFF_W + 10;
    localparam int NUMD_W    = DIFFK_W + GAIN_W;
    localparam int INT_W     = 24;
    localparam int SUM1_W    = PTERM_W + 1;
    localparam int SUM2_W    = NUMD_W + 1;
    localparam int PID_W     = 24;
    localparam int DRIVE_W   = 8;
    localparam int DIV_W     = NUMI_W - 1;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [POS_W-1:0] CENTER = POS_W'(320);
    localparam logic [MS_W-1:0] FIRST_MS = MS_W'(1000);
    localparam logic [MS_W-1:0] MIN_MS = MS_W'(1);
    localparam logic [MS_W-1:0] MS_PER_S = MS_W'(1000);
    localparam logic signed [10:0] MS_PER_S_S = 11'sd1000;
    localparam logic signed [14:0] FALLBACK_OFS = 15'sd960;
    localparam logic signed [14:0] USED_MAX = 15'sd4095;
    localparam logic signed [14:0] USED_MIN = -15'sd2048;
    localparam logic signed [INT_W-1:0] INT_MAX = INT_W'(30 << FRAC_BITS);
    localparam logic signed [INT_W-1:0] INT_MIN = INT_W'(-(30 << FRAC_BITS));
    localparam logic signed [PID_W-1:0] PID_MAX = PID_W'(99 << FRAC_BITS);
    localparam logic signed [PID_W-1:0] PID_MIN = PID_W'(-(100 << FRAC_BITS));
    localparam logic signed [PID_W-1:0] ROUND_BIAS = PID_W'((1 << FRAC_BITS) - 1);

    localparam logic [REG_IDX_W-1:0] REG_TARGET = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_P = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_I = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_D = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW = 3'd4;

    localparam logic [POS_W-1:0] RST_TARGET = POS_W'(320);
    localparam logic [GAIN_W-1:0] RST_GAIN_P = GAIN_W'(9830);
    localparam logic [GAIN_W-1:0] RST_GAIN_I = GAIN_W'(0);
    localparam logic [GAIN_W-1:0] RST_GAIN_D = GAIN_W'(1311);
    localparam logic [POS_W-1:0] RST_WINDOW = POS_W'(640);

    typedef struct packed {
        logic [POS_W-1:0]  target;
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [POS_W-1:0]  window;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ERR,
        OP_MUL1,
        OP_MUL2,
        OP_MUL3,
        OP_DIVI,
        OP_INC,
        OP_INT,
        OP_DIVD,
        OP_DTERM,
        OP_SUM1,
        OP_SUM2,
        OP_CLAMP,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        logic div_done;
        logic out_stall;
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_DIVI,
        ST_WAITI,
        ST_INT,
        ST_DIVD,
        ST_WAITD,
        ST_SUM1,
        ST_SUM2,
        ST_CLAMP,
        ST_OUT
    } ctrl_state_t;

endpackage

@@ src/ppc_regs.sv @@
// Configuration register file behind the APB-style port.
module ppc_regs
    import ppc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output cfg_t              cfg
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx   = paddr[ADDR_W-1:2];
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_TARGET: cfg_next.target = pwdata[POS_W-1:0];
                REG_GAIN_P: cfg_next.gain_p = pwdata[GAIN_W-1:0];
                REG_GAIN_I: cfg_next.gain_i = pwdata[GAIN_W-1:0];
                REG_GAIN_D: cfg_next.gain_d = pwdata[GAIN_W-1:0];
                REG_WINDOW: cfg_next.window = pwdata[POS_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_TARGET: prdata = DATA_W'(cfg_reg.target);
            REG_GAIN_P: prdata = DATA_W'(cfg_reg.gain_p);
            REG_GAIN_I: prdata = DATA_W'(cfg_reg.gain_i);
            REG_GAIN_D: prdata = DATA_W'(cfg_reg.gain_d);
            REG_WINDOW: prdata = DATA_W'(cfg_reg.window);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target <= RST_TARGET;
            cfg_reg.gain_p <= RST_GAIN_P;
            cfg_reg.gain_i <= RST_GAIN_I;
            cfg_reg.gain_d <= RST_GAIN_D;
            cfg_reg.window <= RST_WINDOW;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ src/ppc_div.sv @@
// Unsigned restoring divider producing two quotient bits per cycle.
module ppc_div
    import ppc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [MS_W-1:0]  divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [DIV_W-1:0]     quo_reg;
    logic [MS_W-1:0]      rem_reg;
    logic [MS_W-1:0]      den_reg;
    logic [MS_W:0]        r1;
    logic [MS_W:0]        r1_sub;
    logic [MS_W:0]        r2;
    logic [MS_W:0]        r2_sub;
    logic                 ge1;
    logic                 ge2;
    logic                 last;

    assign last = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    always_comb
    begin
        r1     = {rem_reg, quo_reg[DIV_W-1]};
        ge1    = (r1 >= {1'b0, den_reg});
        r1_sub = ge1 ? (r1 - {1'b0, den_reg}) : r1;
        r2     = {r1_sub[MS_W-1:0], quo_reg[DIV_W-2]};
        ge2    = (r2 >= {1'b0, den_reg});
        r2_sub = ge2 ? (r2 - {1'b0, den_reg}) : r2;
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-3:0], ge1, ge2};
            rem_reg <= r2_sub[MS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ src/ppc_dp.sv @@
// Datapath: fallback position, error, PID terms, clamps and output register.
module ppc_dp
    import ppc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  dp_op_t                    op,
    input  logic [POS_W-1:0]          in_position,
    input  logic [MS_W-1:0]           in_elapsed_ms,
    input  logic                      out_ready,
    output status_t                   status,
    output logic                      out_valid,
    output logic signed [DRIVE_W-1:0] out_drive,
    output logic signed [USED_W-1:0]  out_used
);

    logic                      first_reg;
    logic                      first_next;
    logic [POS_W-1:0]          lgp_reg;
    logic [POS_W-1:0]          lgp_next;
    logic signed [ERR_W-1:0]   prev_err_reg;
    logic signed [ERR_W-1:0]   prev_err_next;
    logic signed [INT_W-1:0]   integ_reg;
    logic signed [INT_W-1:0]   integ_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;

    logic [POS_W-1:0]          pos_reg;
    logic [MS_W-1:0]           ms_reg;
    logic signed [USED_W-1:0]  used_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [PRODA_W-1:0] proda_reg;
    logic signed [PTERM_W-1:0] pterm_reg;
    logic signed [NUMI_W-1:0]  numi_reg;
    logic signed [DIFFK_W-1:0] diffk_reg;
    logic signed [NUMD_W-1:0]  numd_reg;
    logic                      div_neg_reg;
    logic signed [NUMI_W-1:0]  inc_reg;
    logic signed [NUMD_W-1:0]  dterm_reg;
    logic signed [SUM1_W-1:0]  sum1_reg;
    logic signed [SUM2_W-1:0]  sum2_reg;
    logic signed [PID_W-1:0]   pid_reg;
    logic signed [DRIVE_W-1:0] out_drive_reg;
    logic signed [USED_W-1:0]  out_used_reg;

    logic signed [14:0]        twice;
    logic signed [14:0]        half_sum;
    logic signed [14:0]        half;
    logic signed [USED_W-1:0]  used_calc;
    logic signed [ERR_W-1:0]   err_calc;
    logic signed [DIFF_W-1:0]  diff_calc;
    logic signed [PRODA_W:0]   proda_full;
    logic signed [PTERM_W:0]   pterm_full;
    logic signed [NUMI_W:0]    numi_full;
    logic signed [DIFFK_W:0]   diffk_full;
    logic signed [NUMD_W:0]    numd_full;
    logic signed [NUMI_W-1:0]  numi_abs;
    logic signed [NUMD_W-1:0]  numd_abs;
    logic signed [NUMI_W-1:0]  quo_s;
    logic signed [NUMD_W-1:0]  quo_d;
    logic signed [NUMI_W:0]    int_sum;
    logic signed [SUM1_W-1:0]  sum1_calc;
    logic signed [SUM2_W-1:0]  sum2_calc;
    logic signed [PID_W-1:0]   drive_sum;

    logic                      div_start;
    logic [DIV_W-1:0]          div_dividend;
    logic [MS_W-1:0]           div_divisor;
    logic                      div_done;
    logic [DIV_W-1:0]          div_quotient;

    // Fallback is 320 + 2.5 * (last good - 320), halved toward zero.
    always_comb
    begin
        twice    = $signed({2'b00, lgp_reg, 2'b00}) + $signed({4'b0000, lgp_reg})
                   - FALLBACK_OFS;
        half_sum = twice + $signed({14'd0, twice[14]});
        half     = half_sum >>> 1;
        if (pos_reg > cfg.window)
        begin
            if (half > USED_MAX)
            begin
                used_calc = USED_MAX[USED_W-1:0];
            end
            else if (half < USED_MIN)
            begin
                used_calc = USED_MIN[USED_W-1:0];
            end
            else
            begin
                used_calc = half[USED_W-1:0];
            end
        end
        else
        begin
            used_calc = $signed({2'b00, pos_reg});
        end
        err_calc = used_calc - $signed({2'b00, cfg.target});
    end

    always_comb
    begin
        diff_calc  = err_reg - prev_err_reg;
        proda_full = err_reg * $signed({1'b0, ms_reg});
        pterm_full = err_reg * $signed({1'b0, cfg.gain_p});
        numi_full  = proda_reg * $signed({1'b0, cfg.gain_i});
        diffk_full = diff_reg * MS_PER_S_S;
        numd_full  = diffk_reg * $signed({1'b0, cfg.gain_d});
        numi_abs   = numi_reg[NUMI_W-1] ? -numi_reg : numi_reg;
        numd_abs   = numd_reg[NUMD_W-1] ? -numd_reg : numd_reg;
        quo_s      = $signed({1'b0, div_quotient});
        quo_d      = $signed({1'b0, div_quotient[NUMD_W-2:0]});
        int_sum    = integ_reg + inc_reg;
        sum1_calc  = pterm_reg + integ_reg;
        sum2_calc  = sum1_reg + dterm_reg;
        drive_sum  = pid_reg + (pid_reg[PID_W-1] ? ROUND_BIAS : '0);
    end

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = numi_abs[DIV_W-1:0];
        div_divisor  = MS_PER_S;
        case (op)
            OP_DIVI:
            begin
                div_start = 1'b1;
            end
            OP_DIVD:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(numd_abs[NUMD_W-2:0]);
                div_divisor  = ms_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    ppc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        first_next     = first_reg;
        lgp_next       = lgp_reg;
        prev_err_next  = prev_err_reg;
        integ_next     = integ_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (op)
            OP_LOAD:
            begin
                first_next = 1'b0;
            end
            OP_ERR:
            begin
                if (pos_reg <= cfg.window)
                begin
                    lgp_next = pos_reg;
                end
            end
            OP_MUL1:
            begin
                prev_err_next = err_reg;
            end
            OP_INT:
            begin
                if (int_sum > INT_MAX)
                begin
                    integ_next = INT_MAX;
                end
                else if (int_sum < INT_MIN)
                begin
                    integ_next = INT_MIN;
                end
                else
                begin
                    integ_next = int_sum[INT_W-1:0];
                end
            end
            OP_OUT:
            begin
                out_valid_next = 1'b1;
            end
            default:
            begin
                first_next = first_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg     <= 1'b1;
            lgp_reg       <= CENTER;
            prev_err_reg  <= '0;
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            first_reg     <= first_next;
            lgp_reg       <= lgp_next;
            prev_err_reg  <= prev_err_next;
            integ_reg     <= integ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                pos_reg <= in_position;
                if (first_reg)
                begin
                    ms_reg <= FIRST_MS;
                end
                else if (in_elapsed_ms == '0)
                begin
                    ms_reg <= MIN_MS;
                end
                else
                begin
                    ms_reg <= in_elapsed_ms;
                end
            end
            OP_ERR:
            begin
                used_reg <= used_calc;
                err_reg  <= err_calc;
            end
            OP_MUL1:
            begin
                diff_reg  <= diff_calc;
                proda_reg <= proda_full[PRODA_W-1:0];
                pterm_reg <= pterm_full[PTERM_W-1:0];
            end
            OP_MUL2:
            begin
                numi_reg  <= numi_full[NUMI_W-1:0];
                diffk_reg <= diffk_full[DIFFK_W-1:0];
            end
            OP_MUL3:
            begin
                numd_reg <= numd_full[NUMD_W-1:0];
            end
            OP_DIVI:
            begin
                div_neg_reg <= numi_reg[NUMI_W-1];
            end
            OP_INC:
            begin
                inc_reg <= div_neg_reg ? -quo_s : quo_s;
            end
            OP_DIVD:
            begin
                div_neg_reg <= numd_reg[NUMD_W-1];
            end
            OP_DTERM:
            begin
                dterm_reg <= div_neg_reg ? -quo_d : quo_d;
            end
            OP_SUM1:
            begin
                sum1_reg <= sum1_calc;
            end
            OP_SUM2:
            begin
                sum2_reg <= sum2_calc;
            end
            OP_CLAMP:
            begin
                if (sum2_reg > PID_MAX)
                begin
                    pid_reg <= PID_MAX;
                end
                else if (sum2_reg < PID_MIN)
                begin
                    pid_reg <= PID_MIN;
                end
                else
                begin
                    pid_reg <= sum2_reg[PID_W-1:0];
                end
            end
            OP_OUT:
            begin
                out_drive_reg <= drive_sum[FRAC_BITS +: DRIVE_W];
                out_used_reg  <= used_reg;
            end
            default:
            begin
                pos_reg <= pos_reg;
            end
        endcase
    end

    assign status.div_done  = div_done;
    assign status.out_stall = out_valid_reg && !out_ready;
    assign out_valid        = out_valid_reg;
    assign out_drive        = out_drive_reg;
    assign out_used         = out_used_reg;

endmodule

@@ src/ppc_ctrl.sv @@
// Controller state machine sequencing the datapath one sample at a time.
module ppc_ctrl
    import ppc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  status_t status,
    output logic    in_ready,
    output dp_op_t  op
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  state_next = in_valid ? ST_ERR : ST_IDLE;
            ST_ERR:   state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_MUL3;
            ST_MUL3:  state_next = ST_DIVI;
            ST_DIVI:  state_next = ST_WAITI;
            ST_WAITI: state_next = status.div_done ? ST_INT : ST_WAITI;
            ST_INT:   state_next = ST_DIVD;
            ST_DIVD:  state_next = ST_WAITD;
            ST_WAITD: state_next = status.div_done ? ST_SUM1 : ST_WAITD;
            ST_SUM1:  state_next = ST_SUM2;
            ST_SUM2:  state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_OUT;
            ST_OUT:   state_next = status.out_stall ? ST_OUT : ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        op       = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                op       = in_valid ? OP_LOAD : OP_NONE;
            end
            ST_ERR:   op = OP_ERR;
            ST_MUL1:  op = OP_MUL1;
            ST_MUL2:  op = OP_MUL2;
            ST_MUL3:  op = OP_MUL3;
            ST_DIVI:  op = OP_DIVI;
            ST_WAITI: op = status.div_done ? OP_INC : OP_NONE;
            ST_INT:   op = OP_INT;
            ST_DIVD:  op = OP_DIVD;
            ST_WAITD: op = status.div_done ? OP_DTERM : OP_NONE;
            ST_SUM1:  op = OP_SUM1;
            ST_SUM2:  op = OP_SUM2;
            ST_CLAMP: op = OP_CLAMP;
            ST_OUT:   op = status.out_stall ? OP_NONE : OP_OUT;
            default:  op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/pid_position_controller_top.sv @@
// Top level of the PID position controller with out-of-window fallback.
//
// Samples arrive as requests on the s_axis channel: a measured position and
// the milliseconds since the previous sample. Each request yields exactly one
// result request on the m_axis channel carrying the clamped drive value and
// the position actually used after fallback substitution.
// The APB-style port holds the target, the three gains and the window width;
// the user must write it only while the block is idle, which the block itself
// does not enforce, and pready is always high. A sample is accepted in the
// idle state only. It then runs through the multiply steps and two passes of
// a shared divider that resolves two quotient bits per cycle, one pass for the
// integral increment and one for the derivative term. The next sample can be
// accepted in the same cycle as the result becomes valid.
// The result sits in an output register; while the receiver stalls, the next
// sample is still accepted, but its finished result waits in the last state,
// with no new sample accepted, until the pending result is taken.
// Reset clears the integral and the previous error, sets the first-sample flag and the
// last good position (320), and restores the register defaults.
module pid_position_controller_top
    import ppc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,  // position [10:0], elapsed_ms [26:11]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata   // drive [7:0], used_position [20:8]
);

    cfg_t                      cfg;
    dp_op_t                    op;
    status_t                   status;
    logic signed [DRIVE_W-1:0] drive;
    logic signed [USED_W-1:0]  used;

    assign pready = 1'b1;

    ppc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    ppc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .status   (status),
        .in_ready (s_axis_tready),
        .op       (op)
    );

    ppc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .op            (op),
        .in_position   (s_axis_tdata[POS_W-1:0]),
        .in_elapsed_ms (s_axis_tdata[POS_W +: MS_W]),
        .out_ready     (m_axis_tready),
        .status        (status),
        .out_valid     (m_axis_tvalid),
        .out_drive     (drive),
        .out_used      (used)
    );

    assign m_axis_tdata = {3'b000, used, drive};

endmodule

@@ src/ppc_checker.sv @@
// Port-level checker for the position controller, bound to the top level.
`include "pid_position_controller_top_assert.svh"

module ppc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    `PPC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `PPC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `PPC_ASSERT_NOW(a_drive_range, clk, rst_n, m_axis_tvalid, ($signed(m_axis_tdata[7:0]) >= -100) && ($signed(m_axis_tdata[7:0]) <= 99))
    `PPC_ASSERT_NOW(a_used_range, clk, rst_n, m_axis_tvalid, ($signed(m_axis_tdata[20:8]) >= -2048) && (m_axis_tdata[23:21] == 3'b000))

endmodule

bind pid_position_controller_top ppc_checker u_checker (.*);
